// ===== design/lhs_pkg.sv =====
package lhs_pkg;

	// input item codes
	typedef enum logic [1:0] {
		ACT_DONE  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic REG_BLOCK_SIZE  = 1'b0;
	localparam logic REG_FLUSH_EVERY = 1'b1;

	localparam int unsigned CFG_W      = 41;
	localparam int unsigned PCT_W      = 14;
	localparam logic [13:0] PCT_SCALE  = 14'd10000;
	localparam logic [63:0] NS_BASE    = 64'd1000;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLR   = 7'b0000010,
		ST_BUCK  = 7'b0000100,
		ST_RMW   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_WALK  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

endpackage

// ===== design/lhs_ram.sv =====
module lhs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/latency_histogram_stats.sv =====
// Latency histogram statistics. Each item is a completion, a clear or a
// percentile query; one result item carries all totals after it. Buckets
// live in a RAM of BUCKET_COUNT 64-bit words with registered read. A
// completion steps through buckets b from 0 to its own bucket (up to
// BUCKET_COUNT-1), found by a shared compare against 1000 shl b, then adds
// one to that bucket by read-modify-write; a failed completion or the unused
// code goes straight to the result; a clear sweeps the RAM; a query does a
// shift-add multiply of the total by the percentile, then walks the buckets
// in turn until the percentile is reached or the last. The input stays
// stalled until the result is taken, so the next item is accepted in the
// cycle after that at the earliest. After reset the RAM is swept through all
// buckets before the first item is taken. Items are handled one at a time.
module latency_histogram_stats #(
	parameter int unsigned BUCKET_COUNT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [lhs_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [63:0]                 latency_ns,
	input  logic                        write_req,
	input  logic                        failed,
	input  logic                        draining,
	input  logic [lhs_pkg::PCT_W-1:0]   percentile_hundredths,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [63:0]                 ok_total,
	output logic [63:0]                 rd_ops,
	output logic [63:0]                 wr_ops,
	output logic [63:0]                 rd_bytes,
	output logic [63:0]                 wr_bytes,
	output logic [63:0]                 errors,
	output logic [63:0]                 flushes,
	output logic [63:0]                 latency_min,
	output logic [63:0]                 latency_max,
	output logic [63:0]                 latency_sum,
	output logic [63:0]                 percentile_ns,
	output logic                        flush_now
);
	import lhs_pkg::*;

	localparam int unsigned BW = $clog2(BUCKET_COUNT);
	localparam logic [BW-1:0] LAST = BW'(BUCKET_COUNT - 1);

	state_t state_q;
	logic [BW-1:0] idx_q;
	logic [6:0] cnt_q;
	logic [40:0] block_q;
	logic [15:0] fevery_q, wpend_q;
	logic [63:0] done_q, rd_q, wr_q, rdb_q, wrb_q, err_q, fl_q, min_q, max_q, sum_q;
	logic [63:0] lat_q, run_q;
	logic [77:0] prod_q, mcand_q;
	logic [13:0] pct_q;

	// RAM
	logic ram_we;
	logic [BW-1:0] ram_wa, ram_ra;
	logic [63:0] ram_wd, ram_rd;
	lhs_ram #(.WIDTH(64), .DEPTH(BUCKET_COUNT)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	// shared bucket bound: 1000 shl idx
	logic [63:0] bound;
	assign bound = NS_BASE << idx_q;

	// run >= ceil(total*pct/10000) is run*10000 >= total*pct;
	// 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
	logic [77:0] run_x, run_sc;
	assign run_x  = {14'd0, run_q};
	assign run_sc = (run_x << 13) + (run_x << 10) + (run_x << 9) + (run_x << 8)
		+ (run_x << 4);

	assign in_stall = (state_q != ST_IDLE) || out_valid;

	// walk reads one bucket ahead in its compare cycle
	assign ram_ra = (state_q == ST_WALK && cnt_q == 7'd1) ? idx_q + 1'b1 : idx_q;

	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q;
		ram_wd = 64'd0;
		if (state_q == ST_CLR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_RMW) begin
			ram_we = 1'b1;
			ram_wd = ram_rd + 64'd1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q  <= 41'd4096;
			fevery_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:  block_q  <= cfg_wdata;
				REG_FLUSH_EVERY: fevery_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q <= '0; cnt_q <= '0; wpend_q <= '0; out_valid <= 1'b0;
			done_q <= '0; rd_q <= '0; wr_q <= '0; rdb_q <= '0; wrb_q <= '0;
			err_q <= '0; fl_q <= '0; min_q <= '1; max_q <= '0; sum_q <= '0;
			percentile_ns <= '0; flush_now <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						lat_q <= latency_ns;
						pct_q <= (percentile_hundredths > PCT_SCALE) ? PCT_SCALE
							: percentile_hundredths;
						idx_q <= '0;
						percentile_ns <= '0;
						flush_now <= 1'b0;
						case (action)
							ACT_DONE: begin
								if (failed) begin
									err_q <= err_q + 64'd1;
								end else begin
									done_q <= done_q + 64'd1;
									if (write_req) begin
										wr_q <= wr_q + 64'd1;
										wrb_q <= wrb_q + 64'(block_q);
									end else begin
										rd_q <= rd_q + 64'd1;
										rdb_q <= rdb_q + 64'(block_q);
									end
									sum_q <= sum_q + latency_ns;
									if (latency_ns < min_q) min_q <= latency_ns;
									if (latency_ns > max_q) max_q <= latency_ns;
								end
								if (!draining && fevery_q != 16'd0 && write_req) begin
									if (wpend_q + 16'd1 >= fevery_q) begin
										wpend_q <= '0;
										fl_q <= fl_q + 64'd1;
										flush_now <= 1'b1;
									end else begin
										wpend_q <= wpend_q + 16'd1;
									end
								end
								state_q <= failed ? ST_OUT : ST_BUCK;
							end
							ACT_CLEAR: begin
								done_q <= '0; rd_q <= '0; wr_q <= '0; rdb_q <= '0;
								wrb_q <= '0; err_q <= '0; fl_q <= '0; min_q <= '1;
								max_q <= '0; sum_q <= '0;
								// clear after an item reports; reset sweep does not
								cnt_q <= 7'd1;
								state_q <= ST_CLR;
							end
							ACT_QUERY: begin
								prod_q <= '0;
								mcand_q <= {14'd0, done_q};
								cnt_q <= '0;
								state_q <= ST_MUL;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_CLR: begin
					if (idx_q == LAST) begin
						idx_q <= '0;
						cnt_q <= '0;
						state_q <= (cnt_q == 7'd1) ? ST_OUT : ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BUCK: begin
					// stop at first bound above latency, or last bucket
					if (lat_q < bound || idx_q == LAST) state_q <= ST_RMW;
					else idx_q <= idx_q + 1'b1;
				end
				ST_RMW: state_q <= ST_OUT;
				ST_MUL: begin
					// total * pct, one multiplier bit a cycle
					if (pct_q[0]) prod_q <= prod_q + mcand_q;
					mcand_q <= mcand_q << 1;
					pct_q <= pct_q >> 1;
					if (cnt_q == 7'd13) begin
						run_q <= '0;
						cnt_q <= '0;
						state_q <= ST_WALK;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_WALK: begin
					// even cycle accumulates the bucket, odd cycle compares
					if (cnt_q == 7'd0) begin
						run_q <= run_q + ram_rd;
						cnt_q <= 7'd1;
					end else if (run_sc >= prod_q || idx_q == LAST) begin
						percentile_ns <= bound;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						cnt_q <= '0;
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ok_total    = done_q;
	assign rd_ops      = rd_q;
	assign wr_ops      = wr_q;
	assign rd_bytes    = rdb_q;
	assign wr_bytes    = wrb_q;
	assign errors      = err_q;
	assign flushes     = fl_q;
	assign latency_min = min_q;
	assign latency_max = max_q;
	assign latency_sum = sum_q;

endmodule

// ===== bench/latency_histogram_stats_test.sv =====
`timescale 1ns / 1ps

module latency_histogram_stats_test;
	import lhs_pkg::*;

	localparam int NBUCK = 32;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [63:0] latency_ns;
	logic write_req;
	logic failed;
	logic draining;
	logic [PCT_W-1:0] percentile_hundredths;
	logic out_valid;
	logic out_stall;
	logic [63:0] ok_total, rd_ops, wr_ops, rd_bytes, wr_bytes, errors;
	logic [63:0] flushes, latency_min, latency_max, latency_sum, percentile_ns;
	logic flush_now;

	latency_histogram_stats uut (.*);

	typedef struct {
		logic [1:0]       act;
		logic [63:0]      lat;
		logic             wr;
		logic             bad;
		logic             drain;
		logic [PCT_W-1:0] pct;
	} req_t;

	typedef struct {
		logic [63:0] total, rd, wrc, rdb, wrb, err, fl, mn, mx, sum, pns;
		logic        fnow;
	} stats_t;

	// predictor state
	logic [40:0] m_block;
	logic [15:0] m_every;
	logic [15:0] m_pending;
	logic [63:0] m_hist [NBUCK];
	stats_t m_st;

	stats_t stats_q[$];
	int fails = 0;
	bit hold_off = 0;
	bit quiet = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_model();
		m_st = '{default: 64'd0, fnow: 1'b0};
		m_st.mn = '1;
		for (int i = 0; i < NBUCK; i++) m_hist[i] = 0;
	endfunction

	function automatic int bucket_for(logic [63:0] lat);
		logic [63:0] lim;
		int b;
		lim = 64'd2000;
		b = 1;
		if (lat < 64'd1000) return 0;
		while (b < NBUCK - 1 && lat >= lim) begin
			b++;
			lim = lim << 1;
		end
		return b;
	endfunction

	function automatic logic [63:0] pct_bound(logic [PCT_W-1:0] p);
		logic [63:0] pc, q, r, tgt, run;
		pc = (p > 14'd10000) ? 64'd10000 : 64'(p);
		q = m_st.total / 64'd10000;
		r = m_st.total % 64'd10000;
		tgt = q * pc + (r * pc + 64'd9999) / 64'd10000;
		run = 0;
		for (int i = 0; i < NBUCK; i++) begin
			run += m_hist[i];
			if (run >= tgt) return 64'd1000 << i;
		end
		return 64'd1000 << (NBUCK - 1);
	endfunction

	// advance the predictor by one item
	function automatic stats_t predict_stats(req_t r);
		m_st.pns = 0;
		m_st.fnow = 0;
		case (action_t'(r.act))
			ACT_DONE: begin
				if (r.bad) m_st.err++;
				else begin
					m_st.total++;
					if (r.wr) begin
						m_st.wrc++;
						m_st.wrb += 64'(m_block);
					end else begin
						m_st.rd++;
						m_st.rdb += 64'(m_block);
					end
					m_st.sum += r.lat;
					if (r.lat < m_st.mn) m_st.mn = r.lat;
					if (r.lat > m_st.mx) m_st.mx = r.lat;
					m_hist[bucket_for(r.lat)]++;
				end
				if (!r.drain && m_every != 0 && r.wr) begin
					m_pending = m_pending + 16'd1;
					if (m_pending >= m_every) begin
						m_pending = 0;
						m_st.fl++;
						m_st.fnow = 1;
					end
				end
			end
			ACT_CLEAR: clear_model();
			ACT_QUERY: m_st.pns = pct_bound(r.pct);
			default: ;
		endcase
		return m_st;
	endfunction

	// drive one item and wait for it to be taken
	task automatic send_item(req_t r);
		while ($urandom_range(99) < 21 && !quiet) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= r.act;
		latency_ns <= r.lat;
		write_req <= r.wr;
		failed <= r.bad;
		draining <= r.drain;
		percentile_hundredths <= r.pct;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		stats_q.push_back(predict_stats(r));
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		if (idx == REG_BLOCK_SIZE) m_block = val;
		else m_every = val[15:0];
	endtask

	task automatic drain_results();
		in_valid <= 0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic req_t rand_req();
		req_t r;
		int k;
		k = $urandom_range(99);
		r.act = (k < 80) ? ACT_DONE : (k < 82) ? ACT_CLEAR : (k < 97) ? ACT_QUERY : ACT_NONE;
		case ($urandom_range(3))
			0: r.lat = {$urandom, $urandom};
			1: r.lat = 64'($urandom_range(999));
			default: r.lat = 64'd1000 << $urandom_range(33) | 64'($urandom_range(1023));
		endcase
		r.wr = 1'($urandom_range(1));
		r.bad = ($urandom_range(9) == 0);
		r.drain = ($urandom_range(7) == 0);
		r.pct = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(10000));
		return r;
	endfunction

	// output side: random stall plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1;
		else out_stall <= hold_off || (!quiet && $urandom_range(99) < 21);
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (stats_q.size() == 0) begin
				$error("result with nothing expected");
				fails++;
			end else begin
				stats_t e;
				e = stats_q.pop_front();
				if (ok_total !== e.total) begin
					$error("ok_total exp %0d got %0d", e.total, ok_total); fails++; end
				if (rd_ops !== e.rd) begin
					$error("rd_ops exp %0d got %0d", e.rd, rd_ops); fails++; end
				if (wr_ops !== e.wrc) begin
					$error("wr_ops exp %0d got %0d", e.wrc, wr_ops); fails++; end
				if (rd_bytes !== e.rdb) begin
					$error("rd_bytes exp %0d got %0d", e.rdb, rd_bytes); fails++; end
				if (wr_bytes !== e.wrb) begin
					$error("wr_bytes exp %0d got %0d", e.wrb, wr_bytes); fails++; end
				if (errors !== e.err) begin
					$error("errors exp %0d got %0d", e.err, errors); fails++; end
				if (flushes !== e.fl) begin
					$error("flushes exp %0d got %0d", e.fl, flushes); fails++; end
				if (latency_min !== e.mn) begin
					$error("latency_min exp %h got %h", e.mn, latency_min); fails++; end
				if (latency_max !== e.mx) begin
					$error("latency_max exp %h got %h", e.mx, latency_max); fails++; end
				if (latency_sum !== e.sum) begin
					$error("latency_sum exp %h got %h", e.sum, latency_sum); fails++; end
				if (percentile_ns !== e.pns) begin
					$error("percentile_ns exp %0d got %0d", e.pns, percentile_ns); fails++; end
				if (flush_now !== e.fnow) begin
					$error("flush_now exp %0d got %0d", e.fnow, flush_now); fails++; end
			end
		end
	end

	// watchdog on cycles without any handshake
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else if (hold_off) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// directed rows: action, latency, write, failed, drain, pct
	req_t dir_rows[] = '{
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd5000},
		'{ACT_DONE, 64'd0, 1'b0, 1'b0, 1'b0, 14'd0},
		'{ACT_DONE, 64'd999, 1'b1, 1'b0, 1'b0, 14'd0},
		'{ACT_DONE, 64'd1000, 1'b1, 1'b0, 1'b1, 14'd0},
		'{ACT_DONE, 64'd1999, 1'b0, 1'b0, 1'b0, 14'd0},
		'{ACT_DONE, 64'd2000, 1'b1, 1'b1, 1'b0, 14'd0},
		'{ACT_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 14'd0},
		'{ACT_DONE, 64'd1000 << 30, 1'b0, 1'b0, 1'b0, 14'd0},
		'{ACT_DONE, 64'd1, 1'b0, 1'b1, 1'b1, 14'd0},
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd0},
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd1},
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd5000},
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd10000},
		'{ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 14'h3FFF},
		'{ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 14'h3FFF},
		'{ACT_CLEAR, 64'd5, 1'b1, 1'b0, 1'b0, 14'd0},
		'{ACT_QUERY, 64'd0, 1'b0, 1'b0, 1'b0, 14'd9999}
	};

	// typed-in results where obvious (index 0 = first query after reset)
	logic [63:0] known_pns [int] = '{0: 64'd1000, 16: 64'd1000};

	initial begin
		req_t r;
		int hold_len;
		arst_n = 0;
		cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
		in_valid = 0; action = 0; latency_ns = 0; write_req = 0; failed = 0;
		draining = 0; percentile_hundredths = 0;
		m_block = 41'd4096; m_every = 0; m_pending = 0;
		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part
		write_reg(REG_FLUSH_EVERY, 41'd2);
		for (int i = 0; i < dir_rows.size(); i++) begin
			send_item(dir_rows[i]);
			if (known_pns.exists(i) && stats_q[$].pns !== known_pns[i]) begin
				$error("percentile_ns row %0d exp %0d pred %0d", i, known_pns[i],
					stats_q[$].pns);
				fails++;
			end
		end
		drain_results();

		// random phases across register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_BLOCK_SIZE, 41'd512); write_reg(REG_FLUSH_EVERY, 41'd1); end
				1: begin write_reg(REG_BLOCK_SIZE, 41'h100_0000_0000);
					write_reg(REG_FLUSH_EVERY, 41'd65535); end
				2: begin write_reg(REG_BLOCK_SIZE, 41'h1FF_FFFF_FFFF);
					write_reg(REG_FLUSH_EVERY, 41'd0); end
				3: begin write_reg(REG_BLOCK_SIZE, 41'd4096 << $urandom_range(28));
					write_reg(REG_FLUSH_EVERY, 41'($urandom_range(1, 9))); end
				4: begin write_reg(REG_BLOCK_SIZE, 41'($urandom));
					write_reg(REG_FLUSH_EVERY, 41'd3); end
				default: begin write_reg(REG_BLOCK_SIZE, 41'd65536);
					write_reg(REG_FLUSH_EVERY, 41'($urandom_range(1, 40))); end
			endcase
			quiet = (ph == 2);
			if (ph == 1) begin
				fork
					begin
						hold_len = 0;
						hold_off = 1;
						while (hold_len < 3000) begin
							@(posedge clk);
							hold_len++;
						end
						hold_off = 0;
					end
				join_none
			end
			for (int n = 0; n < 270; n++) begin
				r = rand_req();
				send_item(r);
			end
			drain_results();
		end
		quiet = 0;

		drain_results();
		if (fails == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
